// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the keyed record table RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define KRT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define KRT_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/krt_pkg.sv -----
// Types and codes of the keyed record table.
// Used by krt_ctrl and keyed_record_table_top; depends on nothing else.
package krt_pkg;

	localparam int KEY_BITS = 31;
	localparam int OP_BITS = 2;
	localparam int STATUS_BITS = 2;
	localparam int PAY_PORT_BITS = 64;
	localparam int COUNT_PORT_BITS = 7;

	typedef enum logic [OP_BITS-1:0] {
		OP_ADD = 2'd0,
		OP_REMOVE = 2'd1,
		OP_GET = 2'd2
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [OP_BITS-1:0] opcode;
		logic [KEY_BITS-1:0] key;
		logic [PAY_PORT_BITS-1:0] payload_in;
	} cmd_t;

	typedef struct packed {
		status_t status;
		logic [PAY_PORT_BITS-1:0] payload_out;
		logic [COUNT_PORT_BITS-1:0] count_out;
	} rsp_t;

endpackage

// ----- rtl/krt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the entries of the keyed record table; no dependencies.
module krt_ram #(
	parameter int WIDTH = 95,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/krt_ctrl.sv -----
// Sequencer of the keyed record table: linear key search, append and compaction.
// Depends on krt_pkg and assert_macros.svh; drives the entry RAM of the top level.
`include "assert_macros.svh"

module krt_ctrl #(
	parameter int TABLE_DEPTH = 64,
	parameter int PAYLOAD_BITS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input krt_pkg::cmd_t cmd,
	output logic busy,
	output logic fin,
	output krt_pkg::rsp_t rsp,
	output logic ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
	output logic [krt_pkg::KEY_BITS+PAYLOAD_BITS-1:0] ram_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
	input logic [krt_pkg::KEY_BITS+PAYLOAD_BITS-1:0] ram_rdata
);
	import krt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W = KEY_BITS + PAYLOAD_BITS;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SRCH = 3'b010,
		S_SHIFT = 3'b100
	} state_t;

	state_t state_q;
	logic [OP_BITS-1:0] op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic accept;
	logic op_valid;
	logic issue;
	logic key_hit;
	logic srch_end;
	logic shift_end;
	logic add_wr;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign op_valid = (cmd.opcode == OP_ADD) || (cmd.opcode == OP_REMOVE) ||
		(cmd.opcode == OP_GET);
	assign issue = ((state_q == S_SRCH) || (state_q == S_SHIFT)) && (idx_q < cnt_q);
	// The comparator sees the entry read in the previous cycle.
	assign key_hit = rd_vld_s1 && (ram_rdata[ENT_W-1 -: KEY_BITS] == key_q);
	assign srch_end = (state_q == S_SRCH) && (key_hit || (!rd_vld_s1 && !issue));
	assign shift_end = (state_q == S_SHIFT) && !rd_vld_s1 && !issue;
	assign add_wr = srch_end && (op_q == OP_ADD) && !key_hit && (cnt_q != DEPTH_C);
	assign ram_raddr = idx_q[IDX_W-1:0];

	always_comb begin
		fin = 1'b0;
		rsp.status = ST_DONE;
		rsp.payload_out = '0;
		rsp.count_out = COUNT_PORT_BITS'(cnt_q);
		ram_we = 1'b0;
		ram_waddr = wr_idx_q;
		ram_wdata = ram_rdata;
		if (accept && !op_valid) begin
			fin = 1'b1;
		end
		if (srch_end) begin
			case (op_q)
				OP_ADD: begin
					fin = 1'b1;
					if (key_hit) begin
						rsp.status = ST_PRESENT;
					end else if (cnt_q == DEPTH_C) begin
						rsp.status = ST_FULL;
					end else begin
						ram_we = 1'b1;
						ram_waddr = cnt_q[IDX_W-1:0];
						ram_wdata = {key_q, pay_q};
						rsp.count_out = COUNT_PORT_BITS'(cnt_q + 1'b1);
					end
				end
				OP_REMOVE: begin
					// A hit goes on to compaction and reports at its end.
					if (!key_hit) begin
						fin = 1'b1;
						rsp.status = ST_ABSENT;
					end
				end
				default: begin
					fin = 1'b1;
					if (key_hit) begin
						rsp.payload_out = PAY_PORT_BITS'(ram_rdata[PAYLOAD_BITS-1:0]);
					end else begin
						rsp.status = ST_ABSENT;
					end
				end
			endcase
		end
		// Each entry read during compaction lands one place lower.
		if ((state_q == S_SHIFT) && rd_vld_s1) begin
			ram_we = 1'b1;
			ram_waddr = wr_idx_q;
			ram_wdata = ram_rdata;
		end
		if (shift_end) begin
			fin = 1'b1;
			rsp.count_out = COUNT_PORT_BITS'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (add_wr) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						rd_vld_s1 <= 1'b0;
						if (op_valid) begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (srch_end) begin
						if ((op_q == OP_REMOVE) && key_hit) begin
							state_q <= S_SHIFT;
							idx_q <= CNT_W'(rd_idx_s1) + 1'b1;
							rd_vld_s1 <= 1'b0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SHIFT: begin
					if (shift_end) begin
						cnt_q <= cnt_q - 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[IDX_W-1:0];
		if (accept) begin
			op_q <= cmd.opcode;
			key_q <= cmd.key;
			pay_q <= cmd.payload_in[PAYLOAD_BITS-1:0];
		end
		if (srch_end) begin
			wr_idx_q <= rd_idx_s1;
		end else if ((state_q == S_SHIFT) && rd_vld_s1) begin
			wr_idx_q <= wr_idx_q + 1'b1;
		end
	end

	`KRT_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= DEPTH_C, "entry count above table depth")
	`KRT_ASSERT(a_add_room, clk, arst_n, add_wr |-> (cnt_q < DEPTH_C), "append into a full table")
	`KRT_ASSERT(a_shift_wr, clk, arst_n, ((state_q == S_SHIFT) && ram_we) |-> ((CNT_W'(wr_idx_q) + 1'b1) < cnt_q), "compaction write beyond held entries")

endmodule

// ----- rtl/keyed_record_table_top.sv -----
// Keyed record table: up to TABLE_DEPTH records of a 31-bit key and a payload word, kept
// in insertion order and searched one entry per cycle. Command word is taken when start
// is high and busy is low. An add or a get holds busy high until the search hits or has
// read every held entry; a remove that hits holds it on while the later entries are moved
// down one per cycle. The search and the compaction are serial because of the entry
// memory's single read port and the one key comparator behind it. The result word is
// shown with done for one cycle, the cycle in which busy falls, and cannot be held off;
// an unused opcode gives its result the cycle after it is taken without raising busy.
// Depends on krt_pkg, krt_ram, krt_ctrl and assert_macros.svh.
`include "assert_macros.svh"

module keyed_record_table_top #(
	parameter int TABLE_DEPTH = 64,
	parameter int PAYLOAD_BITS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input krt_pkg::cmd_t cmd,
	output logic busy,
	output logic done,
	output krt_pkg::rsp_t result
);
	import krt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int ENT_W = KEY_BITS + PAYLOAD_BITS;

	logic fin;
	rsp_t rsp;
	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ENT_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [ENT_W-1:0] ram_rdata;
	logic done_q;
	rsp_t result_q;

	krt_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.fin(fin),
		.rsp(rsp),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	krt_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The result word is registered so the sequencer can take the next command at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_q <= rsp;
		end
	end

	assign done = done_q;
	assign result = result_q;

	`KRT_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result shown while still busy")
	`KRT_ASSERT(a_accept_progress, clk, arst_n, (start && !busy) |=> (busy || done), "command word taken but neither busy nor done")
	`KRT_ASSERT_NR(a_reset_quiet, clk, !arst_n |=> !done, "result strobe right after reset")

endmodule
